// ===== design/prf_pkg.sv =====
// Shared types, codes and helper functions of the PNG adaptive row filter unit.
`default_nettype none

package prf_pkg;

  localparam int NUM_FILTERS = 5;
  localparam int SUM_W       = 20;
  localparam int ROW_BYTES_W = 13;
  localparam int BPP_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [SUM_W-1:0]       SUM_MAX         = '1;
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 13'd1024;
  localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd4;
  localparam logic [BPP_W-1:0]       BPP_MIN         = 3'd1;
  localparam logic [BPP_W-1:0]       BPP_MAX         = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam int TUSER_CMD_BIT = 0;
  localparam int TUSER_SOI_BIT = 1;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filter_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CALC,
    ST_ACCUM,
    ST_PICK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_REJECT,
    RES_FILTER,
    RES_RESIDUAL
  } res_kind_t;

  typedef struct packed {
    logic      take;
    logic      start;
    logic      read;
    logic      calc;
    logic      accum;
    logic      pick;
    logic      res_set;
    res_kind_t kind;
    logic      load;
  } cmd_t;

  typedef struct packed {
    logic fetch;
    logic draining;
    logic bp_zero;
    logic row_end;
    logic pick_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] abs_byte(input logic [7:0] v);
    abs_byte = v[7] ? 8'(~v + 8'd1) : v;
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] dbc;
    logic signed [10:0] dac;
    logic signed [10:0] dsum;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    dbc  = $signed({3'b000, b}) - $signed({3'b000, c});
    dac  = $signed({3'b000, a}) - $signed({3'b000, c});
    dsum = dbc + dac;
    pa   = dbc[10] ? 11'(-dbc) : 11'(dbc);
    pb   = dac[10] ? 11'(-dac) : 11'(dac);
    pc   = dsum[10] ? 11'(-dsum) : 11'(dsum);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/png_adaptive_row_filter_unit.sv =====
// Top level of the PNG adaptive row filter unit.
// Input stream: s_tuser selects the transaction kind (bit 0: 0 write pixel byte, 1 fetch
// encoded byte; bit 1: start of image), s_tdata carries the raw pixel byte on writes.
// Output stream: one transaction per input transaction. m_tdata holds the encoded byte,
// a valid flag and a reject flag; m_tuser marks the filter type byte, m_tlast the last
// residual byte of a row. Writes fill a row; when the row is complete the filter with
// the smallest sum of absolute residuals is picked, and fetches then read out the filter
// type byte followed by the filtered row. Writes during readout and fetches outside it
// come back rejected.
// One transaction at a time: a write or residual fetch passes through decode and row
// buffer read, residual, sum update and output; a reject or filter byte goes from decode
// straight to output, and the row's last write adds a scan of the five sums before output.
// The next transaction is accepted only after the result of the last one is loaded.
// The registered row buffer read and the serial sum scan account for these steps.
// The next transaction is accepted while a result still waits in the output register;
// if the receiver stalls, the following result is held until the register frees.
// The row buffers are two swapping banks of MAX_ROW_BYTES bytes; their contents are
// unknown after reset and need no clearing. Synchronous reset returns the registers to
// 1024 bytes per row and 4 bytes per pixel and empties the output register.
`default_nettype none

module png_adaptive_row_filter_unit #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // pixel_byte
  input  logic [1:0]                     s_tuser,   // command, start_of_image
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // out_byte, out_valid, rejected, zero pad
  output logic                           m_tuser,   // is_filter_byte
  output logic                           m_tlast,   // last_of_row
  input  logic                           cfg_we,
  input  logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import prf_pkg::*;

  cmd_t    cmd;
  status_t status;

  prf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  prf_datapath #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== design/prf_line_buf.sv =====
// One row buffer bank: single write port, single registered read port.
`default_nettype none

module prf_line_buf #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/prf_datapath.sv =====
// Datapath: row buffers, neighbor history, residuals, filter sums, result and output register.
`default_nettype none

module prf_datapath #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  prf_pkg::cmd_t                    cmd,
  output prf_pkg::status_t                 status,
  input  logic [7:0]                       s_tdata,
  input  logic [1:0]                       s_tuser,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [15:0]                      m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [prf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import prf_pkg::*;

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int LW = $clog2(MAX_ROW_BYTES + 1);

  logic                   item_fetch;
  logic                   item_soi;
  logic [7:0]             item_pix;
  logic [ROW_BYTES_W-1:0] row_bytes;
  logic [BPP_W-1:0]       bpp;
  logic [LW-1:0]          bp;
  logic                   first_row;
  logic                   draining;
  filter_t                chosen;
  logic [SUM_W-1:0]       sums [NUM_FILTERS];
  logic                   sel;
  logic [7:0]             cur_hist [4];
  logic [7:0]             up_hist [4];
  logic [7:0]             res [NUM_FILTERS];
  logic [7:0]             res_next [NUM_FILTERS];
  logic [2:0]             pick_idx;
  logic [2:0]             best;
  logic [SUM_W-1:0]       best_sum;
  logic [SUM_W-1:0]       pick_sum;
  logic                   pick_lt;
  logic [7:0]             pend_byte;
  logic                   pend_valid;
  logic                   pend_isf;
  logic                   pend_last;
  logic                   pend_rej;
  logic [7:0]             out_byte;
  logic                   out_valid;
  logic                   out_isf;
  logic                   out_last;
  logic                   out_rej;
  logic [7:0]             chosen_res;

  logic [LW-1:0]    len;
  logic [BPP_W-1:0] bpp_eff;
  logic [LW-1:0]    pos_full;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    rd_addr;
  logic             row_end;
  logic             has_left;
  logic [1:0]       hist_sel;
  logic [7:0]       cur_byte;
  logic [7:0]       left_a;
  logic [7:0]       up_b;
  logic [7:0]       diag_c;
  logic [7:0]       rdata0;
  logic [7:0]       rdata1;
  logic [7:0]       cur_rdata;
  logic [7:0]       up_rdata;
  logic             mem_we;

  // effective register values
  always_comb begin
    if (row_bytes == '0) begin
      len = LW'(1);
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      len = LW'(MAX_ROW_BYTES);
    end else begin
      len = LW'(row_bytes);
    end
    if (bpp < BPP_MIN) begin
      bpp_eff = BPP_MIN;
    end else if (bpp > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = bpp;
    end
  end

  assign pos_full = (item_fetch == CMD_FETCH) ? bp - LW'(1) : bp;
  assign pos      = pos_full[AW-1:0];
  assign rd_addr  = (item_fetch == CMD_WRITE && item_soi) ? '0 : pos;
  assign row_end  = ({1'b0, pos_full} + (LW+1)'(1)) >= {1'b0, len};
  assign has_left = pos_full >= LW'(bpp_eff);
  assign hist_sel = 2'(bpp_eff - BPP_MIN);

  assign cur_rdata = sel ? rdata1 : rdata0;
  assign up_rdata  = sel ? rdata0 : rdata1;
  assign mem_we    = cmd.calc && (item_fetch == CMD_WRITE);

  prf_line_buf #(.DEPTH(MAX_ROW_BYTES)) u_bank0 (
    .clk   (clk),
    .we    (mem_we && !sel),
    .waddr (pos),
    .wdata (item_pix),
    .re    (cmd.read),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  prf_line_buf #(.DEPTH(MAX_ROW_BYTES)) u_bank1 (
    .clk   (clk),
    .we    (mem_we && sel),
    .waddr (pos),
    .wdata (item_pix),
    .re    (cmd.read),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  // residuals of the five filters
  always_comb begin
    cur_byte = (item_fetch == CMD_FETCH) ? cur_rdata : item_pix;
    left_a   = has_left ? cur_hist[hist_sel] : 8'd0;
    up_b     = first_row ? 8'd0 : up_rdata;
    diag_c   = (has_left && !first_row) ? up_hist[hist_sel] : 8'd0;
    res_next[FILT_NONE]  = cur_byte;
    res_next[FILT_SUB]   = cur_byte - left_a;
    res_next[FILT_UP]    = cur_byte - up_b;
    res_next[FILT_AVG]   = cur_byte - 8'(({1'b0, left_a} + {1'b0, up_b}) >> 1);
    res_next[FILT_PAETH] = cur_byte - paeth(left_a, up_b, diag_c);
  end

  always_comb begin
    case (pick_idx)
      3'(FILT_NONE):  pick_sum = sums[FILT_NONE];
      3'(FILT_SUB):   pick_sum = sums[FILT_SUB];
      3'(FILT_UP):    pick_sum = sums[FILT_UP];
      3'(FILT_AVG):   pick_sum = sums[FILT_AVG];
      3'(FILT_PAETH): pick_sum = sums[FILT_PAETH];
      default:        pick_sum = SUM_MAX;
    endcase
    pick_lt = pick_sum < best_sum;
  end

  always_comb begin
    case (chosen)
      FILT_NONE:  chosen_res = res[FILT_NONE];
      FILT_SUB:   chosen_res = res[FILT_SUB];
      FILT_UP:    chosen_res = res[FILT_UP];
      FILT_AVG:   chosen_res = res[FILT_AVG];
      FILT_PAETH: chosen_res = res[FILT_PAETH];
      default:    chosen_res = res[FILT_NONE];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= ROW_BYTES_RESET;
      bpp       <= BPP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_BYTES: row_bytes <= cfg_data[ROW_BYTES_W-1:0];
        REG_BPP:       bpp       <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_fetch <= s_tuser[TUSER_CMD_BIT];
      item_soi   <= s_tuser[TUSER_SOI_BIT];
      item_pix   <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp        <= '0;
      first_row <= 1'b1;
      draining  <= 1'b0;
      chosen    <= FILT_NONE;
      sel       <= 1'b0;
      pick_idx  <= '0;
      best      <= '0;
      best_sum  <= SUM_MAX;
      for (int f = 0; f < NUM_FILTERS; f++) begin
        sums[f] <= '0;
      end
    end else begin
      if (cmd.start && item_soi) begin
        first_row <= 1'b1;
        bp        <= '0;
        for (int f = 0; f < NUM_FILTERS; f++) begin
          sums[f] <= '0;
        end
      end
      if (cmd.res_set && cmd.kind == RES_FILTER) begin
        bp <= LW'(1);
      end
      if (cmd.accum) begin
        if (item_fetch == CMD_WRITE) begin
          for (int f = 0; f < NUM_FILTERS; f++) begin
            logic [SUM_W:0] s;
            s = {1'b0, sums[f]} + (SUM_W+1)'(abs_byte(res[f]));
            sums[f] <= s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
          end
          if (row_end) begin
            pick_idx <= '0;
            best     <= '0;
            best_sum <= SUM_MAX;
          end else begin
            bp <= pos_full + LW'(1);
          end
        end else if (row_end) begin
          sel       <= ~sel;
          first_row <= 1'b0;
          draining  <= 1'b0;
          bp        <= '0;
          for (int f = 0; f < NUM_FILTERS; f++) begin
            sums[f] <= '0;
          end
        end else begin
          bp <= bp + LW'(1);
        end
      end
      if (cmd.pick) begin
        if (pick_lt) begin
          best     <= pick_idx;
          best_sum <= pick_sum;
        end
        pick_idx <= pick_idx + 3'd1;
        if (status.pick_last) begin
          chosen   <= filter_t'(pick_lt ? pick_idx : best);
          draining <= 1'b1;
          bp       <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        res[f] <= res_next[f];
      end
      cur_hist[0] <= cur_byte;
      up_hist[0]  <= up_rdata;
      for (int i = 1; i < 4; i++) begin
        cur_hist[i] <= cur_hist[i-1];
        up_hist[i]  <= up_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.kind)
        RES_REJECT: begin
          pend_byte  <= 8'd0;
          pend_valid <= 1'b0;
          pend_isf   <= 1'b0;
          pend_last  <= 1'b0;
          pend_rej   <= 1'b1;
        end
        RES_FILTER: begin
          pend_byte  <= 8'(chosen);
          pend_valid <= 1'b1;
          pend_isf   <= 1'b1;
          pend_last  <= 1'b0;
          pend_rej   <= 1'b0;
        end
        RES_RESIDUAL: begin
          pend_byte  <= chosen_res;
          pend_valid <= 1'b1;
          pend_isf   <= 1'b0;
          pend_last  <= row_end;
          pend_rej   <= 1'b0;
        end
        default: begin
          pend_byte  <= 8'd0;
          pend_valid <= 1'b0;
          pend_isf   <= 1'b0;
          pend_last  <= 1'b0;
          pend_rej   <= 1'b0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte  <= pend_byte;
      out_valid <= pend_valid;
      out_isf   <= pend_isf;
      out_last  <= pend_last;
      out_rej   <= pend_rej;
    end
  end

  assign m_tdata = {6'b000000, out_rej, out_valid, out_byte};
  assign m_tuser = out_isf;
  assign m_tlast = out_last;

  assign status.fetch     = item_fetch;
  assign status.draining  = draining;
  assign status.bp_zero   = (bp == '0);
  assign status.row_end   = row_end;
  assign status.pick_last = (pick_idx == 3'(NUM_FILTERS - 1));
  assign status.out_free  = !m_tvalid || m_tready;

  assert property (@(posedge clk) disable iff (rst) $rose(draining) |-> bp == '0)
    else $error("readout entered with nonzero byte counter");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_isf |-> out_valid && !out_rej && out_byte <= 8'(FILT_PAETH))
    else $error("filter type byte malformed");

endmodule

`default_nettype wire

// ===== design/prf_ctrl.sv =====
// Controller FSM: sequences decode, buffer read, residual, sum update, filter pick and output.
`default_nettype none

module prf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  prf_pkg::status_t  status,
  output prf_pkg::cmd_t     cmd
);

  import prf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.fetch == CMD_WRITE) begin
          if (status.draining) begin
            cmd.res_set = 1'b1;
            cmd.kind    = RES_REJECT;
            state_next  = ST_EMIT;
          end else begin
            cmd.start  = 1'b1;
            cmd.read   = 1'b1;
            state_next = ST_CALC;
          end
        end else if (!status.draining) begin
          cmd.res_set = 1'b1;
          cmd.kind    = RES_REJECT;
          state_next  = ST_EMIT;
        end else if (status.bp_zero) begin
          cmd.res_set = 1'b1;
          cmd.kind    = RES_FILTER;
          state_next  = ST_EMIT;
        end else begin
          cmd.read   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum   = 1'b1;
        cmd.res_set = 1'b1;
        cmd.kind    = (status.fetch == CMD_FETCH) ? RES_RESIDUAL : RES_NONE;
        if (status.fetch == CMD_WRITE && status.row_end) begin
          state_next = ST_PICK;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        if (status.pick_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |-> status.out_free)
    else $error("output register overwritten while held");

  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken before the first finished");

  assert property (@(posedge clk) disable iff (rst) cmd.read |=> cmd.calc)
    else $error("row buffer read data not consumed in the next cycle");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the PNG adaptive row filter unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prf_pkg::*;

  localparam int ROW_CAP = 4096;

  typedef struct packed {
    logic [7:0] code;
    logic       valid;
    logic       filt;
    logic       last;
    logic       rej;
  } enc_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [1:0]            s_tuser = '0;   // command, start_of_image
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // out_byte, out_valid, rejected, zero pad
  logic                  m_tuser;        // is_filter_byte
  logic                  m_tlast;        // last_of_row
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  png_adaptive_row_filter_unit #(.MAX_ROW_BYTES(ROW_CAP)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]       prev_row [ROW_CAP];
  logic [7:0]       this_row [ROW_CAP];
  logic [SUM_W-1:0] filt_sums [NUM_FILTERS];
  int               row_pos;
  bit               top_row;
  bit               in_readout;
  filter_t          picked;
  logic [12:0]      cfg_len;
  logic [2:0]       cfg_bpp;

  enc_result_t awaited_bytes [$];

  bit   src_gaps = 1'b1;
  bit   sink_gaps = 1'b1;
  int   hold_request = 0;
  int   stall_left = 0;
  int   errors = 0;
  int   items_sent = 0;
  int   work_items = 0;
  int   cfg_writes = 0;
  int   rows_done = 0;
  int   rejects_seen = 0;
  int   picks [NUM_FILTERS];
  logic [7:0] last_pix = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end

  function automatic int row_len_now();
    if (cfg_len == 0) return 1;
    if (cfg_len > ROW_CAP) return ROW_CAP;
    return int'(cfg_len);
  endfunction

  function automatic int pixel_step_now();
    if (cfg_bpp == 0) return 1;
    if (cfg_bpp > 4) return 4;
    return int'(cfg_bpp);
  endfunction

  function automatic logic [7:0] residual_of(input filter_t f, input int x);
    int bpp, xi, a, b, c, p, pa, pb, pc, pred;
    bit has_left;
    bpp = pixel_step_now();
    xi = x % ROW_CAP;
    has_left = xi >= bpp;
    a = has_left ? int'(this_row[xi - bpp]) : 0;
    b = top_row ? 0 : int'(prev_row[xi]);
    c = (!top_row && has_left) ? int'(prev_row[xi - bpp]) : 0;
    case (f)
      FILT_NONE: pred = 0;
      FILT_SUB:  pred = a;
      FILT_UP:   pred = b;
      FILT_AVG:  pred = (a + b) >> 1;
      default: begin
        p = a + b - c;
        pa = p > a ? p - a : a - p;
        pb = p > b ? p - b : b - p;
        pc = p > c ? p - c : c - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
    endcase
    return 8'(int'(this_row[xi]) - pred);
  endfunction

  function automatic void clear_sums();
    for (int f = 0; f < NUM_FILTERS; f++) filt_sums[f] = '0;
  endfunction

  function automatic enc_result_t encode_byte(input logic cmd, input logic [7:0] pix,
                                              input logic soi);
    enc_result_t r;
    int len, x, idx, best, mag;
    logic [7:0] v;
    logic [SUM_W:0] s;
    r = '0;
    len = row_len_now();
    if (cmd == CMD_WRITE) begin
      if (in_readout) begin
        r.rej = 1'b1;
      end else begin
        if (soi) begin
          top_row = 1'b1;
          row_pos = 0;
          clear_sums();
        end
        x = row_pos % ROW_CAP;
        this_row[x] = pix;
        for (int f = 0; f < NUM_FILTERS; f++) begin
          v = residual_of(filter_t'(f), x);
          mag = v < 128 ? int'(v) : 256 - int'(v);
          s = (SUM_W+1)'(filt_sums[f]) + (SUM_W+1)'(mag);
          filt_sums[f] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
        end
        if (x + 1 >= len) begin
          best = 0;
          for (int f = 1; f < NUM_FILTERS; f++)
            if (filt_sums[f] < filt_sums[best]) best = f;
          picked = filter_t'(best);
          in_readout = 1'b1;
          row_pos = 0;
        end else begin
          row_pos = x + 1;
        end
      end
    end else begin
      if (!in_readout) begin
        r.rej = 1'b1;
      end else if (row_pos == 0) begin
        r.code = 8'(picked);
        r.valid = 1'b1;
        r.filt = 1'b1;
        row_pos = 1;
      end else begin
        idx = (row_pos - 1) % ROW_CAP;
        r.code = residual_of(picked, idx);
        r.valid = 1'b1;
        if (idx + 1 >= len) begin
          r.last = 1'b1;
          for (int i = 0; i < ROW_CAP; i++) prev_row[i] = this_row[i];
          top_row = 1'b0;
          in_readout = 1'b0;
          row_pos = 0;
          clear_sums();
        end else begin
          row_pos = idx + 2;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] pix, input logic soi);
    logic [1:0] u;
    enc_result_t r;
    u = '0;
    u[TUSER_CMD_BIT] = cmd;
    u[TUSER_SOI_BIT] = soi;
    while (src_gaps && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= u;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = encode_byte(cmd, pix, soi);
    awaited_bytes.insert(awaited_bytes.size(), r);
    items_sent++;
    if (!r.rej) work_items++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(input logic [12:0] len, input logic [2:0] bpp);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROW_BYTES;
    cfg_data <= len;
    @(posedge clk);
    cfg_len = len;
    cfg_index <= REG_BPP;
    cfg_data <= {10'($urandom), bpp};
    @(posedge clk);
    cfg_bpp = bpp;
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [7:0] gen_pixel(input int style, input int x);
    int jitter;
    jitter = $urandom_range(0, 6) - 3;
    case (style)
      0: last_pix = 8'($urandom);
      1: last_pix = 8'(int'(last_pix) + jitter);
      2: last_pix = 8'(int'(prev_row[x % ROW_CAP]) + jitter);
      default: if ($urandom_range(0, 15) == 0) last_pix = 8'($urandom);
    endcase
    return last_pix;
  endfunction

  task automatic read_row(input bit noisy);
    while (in_readout) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_item(CMD_WRITE, 8'($urandom), 1'($urandom));
      send_item(CMD_FETCH, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic encode_row(input logic soi_first, input bit noisy);
    int len, style, k;
    logic first;
    len = row_len_now();
    style = $urandom_range(0, 3);
    first = soi_first;
    // abandoned partial row, restarted by a start of image
    if (noisy && len > 1 && $urandom_range(0, 24) == 0) begin
      k = $urandom_range(1, len - 1);
      for (int x = 0; x < k; x++)
        send_item(CMD_WRITE, gen_pixel(style, x), x == 0 ? first : 1'b0);
      first = 1'b1;
    end
    for (int x = 0; x < len; x++) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_item(CMD_FETCH, 8'($urandom), 1'($urandom));
      send_item(CMD_WRITE, gen_pixel(style, x), x == 0 ? first : 1'b0);
    end
    read_row(noisy);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < 100)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_output();
    enc_result_t want;
    if (awaited_bytes.size() == 0) begin
      report_mismatch("unexpected transaction", m_tdata, 16'd0);
      return;
    end
    want = awaited_bytes.pop_front();
    if (m_tdata[7:0] !== want.code)
      report_mismatch("out_byte", 16'(m_tdata[7:0]), 16'(want.code));
    if (m_tdata[8] !== want.valid)
      report_mismatch("out_valid", 16'(m_tdata[8]), 16'(want.valid));
    if (m_tdata[9] !== want.rej)
      report_mismatch("rejected", 16'(m_tdata[9]), 16'(want.rej));
    if (m_tdata[15:10] !== 6'd0)
      report_mismatch("tdata padding", 16'(m_tdata[15:10]), 16'd0);
    if (m_tuser !== want.filt)
      report_mismatch("is_filter_byte", 16'(m_tuser), 16'(want.filt));
    if (m_tlast !== want.last)
      report_mismatch("last_of_row", 16'(m_tlast), 16'(want.last));
    if (want.last) rows_done++;
    if (want.rej) rejects_seen++;
    if (want.filt && want.code < NUM_FILTERS) picks[3'(want.code)]++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_output();
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(sink_gaps && $urandom_range(0, 99) < 35);
    end
  end

  // reset registers: 1024 bytes per row, 4 bytes per pixel, first row pending;
  // the readout is cut short by shrinking the row length
  task automatic test_reset_defaults();
    send_item(CMD_FETCH, 8'hff, 1'b1);
    for (int x = 0; x < row_len_now(); x++)
      send_item(CMD_WRITE, gen_pixel(1, x), 1'b0);
    repeat (9) send_item(CMD_FETCH, 8'($urandom), 1'b0);
    wait_idle();
    set_config(13'd16, BPP_RESET);
    read_row(1'b0);
  endtask

  task automatic test_directed_cases();
    wait_idle();
    set_config(13'd4, 3'd1);
    send_item(CMD_FETCH, 8'h00, 1'b0);
    send_item(CMD_WRITE, 8'h00, 1'b1);
    send_item(CMD_WRITE, 8'hff, 1'b0);
    send_item(CMD_WRITE, 8'h80, 1'b0);
    send_item(CMD_WRITE, 8'h7f, 1'b0);
    send_item(CMD_WRITE, 8'h05, 1'b1);   // dropped, readout in progress
    read_row(1'b0);
    send_item(CMD_FETCH, 8'h00, 1'b1);
    send_item(CMD_WRITE, 8'h01, 1'b0);
    send_item(CMD_WRITE, 8'hfe, 1'b0);
    send_item(CMD_WRITE, 8'h00, 1'b0);
    send_item(CMD_WRITE, 8'hc8, 1'b0);
    read_row(1'b0);
    // partial row thrown away by start of image
    send_item(CMD_WRITE, 8'h0a, 1'b0);
    send_item(CMD_WRITE, 8'h14, 1'b0);
    send_item(CMD_WRITE, 8'h1e, 1'b1);
    send_item(CMD_WRITE, 8'h28, 1'b0);
    send_item(CMD_WRITE, 8'h32, 1'b0);
    send_item(CMD_WRITE, 8'h3c, 1'b0);
    read_row(1'b0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_config(13'd0, 3'd0);
    encode_row(1'b1, 1'b0);
    encode_row(1'b0, 1'b0);
    wait_idle();
    set_config(13'd12, 3'd7);
    encode_row(1'b1, 1'b0);
    encode_row(1'b0, 1'b0);
    wait_idle();
    // oversized length must not end the row early
    set_config(13'h1fff, 3'd5);
    for (int x = 0; x < 20; x++) send_item(CMD_WRITE, 8'($urandom), x == 0);
    wait_idle();
    set_config(13'd20, 3'd5);
    send_item(CMD_WRITE, 8'($urandom), 1'b0);
    read_row(1'b0);
  endtask

  task automatic test_config_change_mid_row();
    wait_idle();
    set_config(13'd16, 3'd2);
    for (int x = 0; x < 10; x++) send_item(CMD_WRITE, 8'($urandom), x == 0);
    wait_idle();
    set_config(13'd6, 3'd2);
    send_item(CMD_WRITE, 8'($urandom), 1'b0);
    repeat (3) send_item(CMD_FETCH, 8'($urandom), 1'b0);
    wait_idle();
    set_config(13'd6, 3'd3);
    read_row(1'b0);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    set_config(13'd8, 3'd2);
    hold_request = 200;
    encode_row(1'b1, 1'b0);
    encode_row(1'b0, 1'b0);
  endtask

  task automatic test_random_images();
    int base, rows, sel;
    logic [12:0] len;
    base = work_items;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    while (items_sent < 1950) begin
      if (work_items - base > 300) begin
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
      end
      wait_idle();
      sel = $urandom_range(0, 9);
      if (sel == 0) len = 13'($urandom_range(0, 4));
      else if (sel < 8) len = 13'($urandom_range(5, 40));
      else len = 13'($urandom_range(41, 120));
      set_config(len, 3'($urandom));
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++)
        encode_row(r == 0 ? 1'b1 : ($urandom_range(0, 19) == 0), 1'b1);
    end
  endtask

  initial begin
    for (int i = 0; i < ROW_CAP; i++) begin
      prev_row[i] = '0;
      this_row[i] = '0;
    end
    for (int f = 0; f < NUM_FILTERS; f++) picks[f] = 0;
    clear_sums();
    row_pos = 0;
    top_row = 1'b1;
    in_readout = 1'b0;
    picked = FILT_NONE;
    cfg_len = ROW_BYTES_RESET;
    cfg_bpp = BPP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_register_extremes();
    test_config_change_mid_row();
    test_output_backpressure();
    test_random_images();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("ran %0d input transactions under %0d register settings, %0d rows read out,",
             items_sent, cfg_writes, rows_done);
    $display("%0d rejected; filters chosen: none %0d sub %0d up %0d avg %0d paeth %0d",
             rejects_seen, picks[0], picks[1], picks[2], picks[3], picks[4]);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
